>>> hw/rtl/rfnm_pkg.sv
// Shared types, constants and operation codes of the radial falloff noise mask.
`timescale 1ns / 1ps

package rfnm_pkg;

    localparam int MAX_SIDE_DEF = 1024;

    localparam int WIDTH_W  = 11;
    localparam int RADIUS_W = 18;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 10;
    localparam int HALF_W   = 10;
    localparam int OUT_W    = 17;
    localparam int TDATA_W  = 56;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 32;

    localparam int IT_W     = 60;
    localparam int IT_QW    = 33;
    localparam int IT_SRCW  = 34;
    localparam int IT_CW    = 6;

    localparam logic [CFG_AW-1:0] REG_MAP_WIDTH = 2'd0;
    localparam logic [CFG_AW-1:0] REG_RADIUS    = 2'd1;
    localparam logic [CFG_AW-1:0] REG_OLD_MIN   = 2'd2;
    localparam logic [CFG_AW-1:0] REG_OLD_MAX   = 2'd3;

    localparam logic [WIDTH_W-1:0]  RST_MAP_WIDTH = 11'd256;
    localparam logic [RADIUS_W-1:0] RST_RADIUS    = 18'd65536;
    localparam logic [VAL_W-1:0]    RST_OLD_MIN   = 32'd0;
    localparam logic [VAL_W-1:0]    RST_OLD_MAX   = 32'd65536;

    localparam logic [OUT_W-1:0] ONE_Q16 = 17'h10000;

    localparam logic MODE_DIV  = 1'b0;
    localparam logic MODE_SQRT = 1'b1;

    localparam logic [IT_CW-1:0] STEPS_FALL = 6'd32;
    localparam logic [IT_CW-1:0] STEPS_SQRT = 6'd17;
    localparam logic [IT_CW-1:0] STEPS_NORM = 6'd16;

    typedef struct packed {
        logic [HALF_W-1:0]   half;
        logic [RADIUS_W-1:0] radius;
        logic [VAL_W-1:0]    old_min;
        logic [VAL_W-1:0]    old_max;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic             mode;
        logic [IT_CW-1:0] steps;
        logic [IT_W-1:0]  num;
        logic [IT_W-1:0]  den;
    } t_it_req;

endpackage

>>> hw/rtl/rfnm_cfg.sv
// Configuration registers with map width clamp and half-width derivation.
`timescale 1ns / 1ps

module rfnm_cfg
    import rfnm_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    output t_cfg              o_cfg
);

    localparam int CMP_W = WIDTH_W + 2;
    localparam logic [CMP_W-1:0]   SIDE_CMP = CMP_W'(MAX_SIDE);
    localparam logic [WIDTH_W-1:0] SIDE_CLP = WIDTH_W'(MAX_SIDE);

    logic [WIDTH_W-1:0]  r_width;
    logic [RADIUS_W-1:0] r_radius;
    logic [VAL_W-1:0]    r_old_min;
    logic [VAL_W-1:0]    r_old_max;
    logic [WIDTH_W-1:0]  w_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= RST_MAP_WIDTH;
            r_radius  <= RST_RADIUS;
            r_old_min <= RST_OLD_MIN;
            r_old_max <= RST_OLD_MAX;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                REG_MAP_WIDTH: r_width   <= i_cfg_wdata[WIDTH_W-1:0];
                REG_RADIUS:    r_radius  <= i_cfg_wdata[RADIUS_W-1:0];
                REG_OLD_MIN:   r_old_min <= i_cfg_wdata[VAL_W-1:0];
                REG_OLD_MAX:   r_old_max <= i_cfg_wdata[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_width = ({2'b00, r_width} > SIDE_CMP) ? SIDE_CLP : r_width;

    assign o_cfg.half    = w_width[WIDTH_W-1:1];
    assign o_cfg.radius  = r_radius;
    assign o_cfg.old_min = r_old_min;
    assign o_cfg.old_max = r_old_max;

endmodule

>>> hw/rtl/rfnm_iter.sv
// Shared iterative compare-subtract unit: restoring divide or integer square root.
`timescale 1ns / 1ps

module rfnm_iter
    import rfnm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_it_req          i_req,
    output logic             o_busy,
    output logic             o_done,
    output logic [IT_QW-1:0] o_result
);

    logic               r_busy;
    logic               r_done;
    logic [IT_CW-1:0]   r_cnt;
    logic               r_mode;
    logic [IT_W-1:0]    r_rem;
    logic [IT_W-1:0]    r_den;
    logic [IT_SRCW-1:0] r_src;
    logic [IT_QW-1:0]   r_quo;

    logic [IT_W-1:0]    w_a;
    logic [IT_W-1:0]    w_b;
    logic [IT_W-1:0]    w_diff;
    logic               w_ge;

    // sqrt: bring down two radicand bits, trial = 4*root + 1
    always_comb begin
        if (r_mode == MODE_SQRT) begin
            w_a = {r_rem[IT_W-3:0], r_src[IT_SRCW-1 -: 2]};
            w_b = {{(IT_W-IT_QW-2){1'b0}}, r_quo, 2'b01};
        end else begin
            w_a = {r_rem[IT_W-2:0], 1'b0};
            w_b = r_den;
        end
        w_ge   = (w_a >= w_b);
        w_diff = w_a - w_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == IT_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mode <= i_req.mode;
            r_rem  <= (i_req.mode == MODE_SQRT) ? '0 : i_req.num;
            r_den  <= i_req.den;
            r_src  <= i_req.num[IT_SRCW-1:0];
            r_quo  <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff : w_a;
            r_quo <= {r_quo[IT_QW-2:0], w_ge};
            r_src <= {r_src[IT_SRCW-3:0], 2'b00};
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_result = r_quo;

endmodule

>>> hw/rtl/radial_falloff_noise_mask.sv
// Top level: radial falloff mask over a noise map, sequencer and running trackers.
//
//  channel | dir | handshake              | word
//  s       | in  | i_s_tvalid/o_s_tready  | pixel_value, column, row; tlast = frame_end
//  m       | out | o_m_tvalid/i_m_tready  | masked_value, running_min/max; tlast = frame_done
//  cfg     | in  | i_cfg_wr_en            | register index and data, no read-back
//
//  An inside pixel uses three multiply stages and, on the one shared compare-subtract
//  unit, a 32-step falloff divide (not on the radius edge), a 17-step square root and a
//  16-step normalizing divide (not when the value is clamped); outside pixels skip it.
//  One pixel is in work at a time; o_s_tready is high only while the sequencer idles.
//  The result sits in an output register, so a stalled m side holds only the next finish.
//  Synchronous active-low reset resets sequencer, trackers, output valid and config registers.
`timescale 1ns / 1ps

module radial_falloff_noise_mask
    import rfnm_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [TDATA_W-1:0] i_s_tdata,   // pixel_value[31:0], column[41:32], row[51:42]
    input  logic               i_s_tlast,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata,   // masked_value[16:0], running_minimum[33:17],
                                            // running_maximum[50:34]
    output logic               o_m_tlast,
    input  logic               i_cfg_wr_en,
    input  logic [CFG_AW-1:0]  i_cfg_addr,
    input  logic [CFG_DW-1:0]  i_cfg_wdata
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL1  = 4'd1;
    localparam logic [3:0] ST_MUL2  = 4'd2;
    localparam logic [3:0] ST_CHECK = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_SQRT  = 4'd5;
    localparam logic [3:0] ST_NORM  = 4'd6;
    localparam logic [3:0] ST_PROD  = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    localparam int RH_W  = RADIUS_W + HALF_W;
    localparam int BIG_W = 2 * RH_W + 1;
    localparam int SQ_W  = 20;
    localparam int D2_W  = SQ_W + 1;
    localparam int NUM_W = D2_W + 32;

    t_cfg                w_cfg;
    t_it_req             w_req;
    logic                w_it_busy;
    logic                w_it_done;
    logic [IT_QW-1:0]    w_it_result;

    logic [3:0]          r_state;
    logic signed [VAL_W-1:0] r_val;
    logic signed [POS_W:0]   r_x;
    logic signed [POS_W:0]   r_y;
    logic                r_last;
    logic [SQ_W-1:0]     r_xx;
    logic [SQ_W-1:0]     r_yy;
    logic [RH_W-1:0]     r_rh;
    logic [D2_W-1:0]     r_d2;
    logic [BIG_W-1:0]    r_big;
    logic [OUT_W-1:0]    r_factor;
    logic [OUT_W-1:0]    r_t;
    logic [OUT_W-1:0]    r_masked;
    logic [OUT_W-1:0]    r_least;
    logic [OUT_W-1:0]    r_greatest;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_masked;
    logic [OUT_W-1:0]    r_out_min;
    logic [OUT_W-1:0]    r_out_max;
    logic                r_out_last;

    logic signed [2*POS_W+1:0] w_xx;
    logic signed [2*POS_W+1:0] w_yy;
    logic [RH_W-1:0]     w_rh;
    logic [2*RH_W-1:0]   w_rh2;
    logic [2*OUT_W-1:0]  w_prod;
    logic [NUM_W-1:0]    w_num;
    logic [BIG_W-1:0]    w_num_ext;
    logic                w_big_zero;
    logic                w_outside;
    logic                w_degen;
    logic                w_low;
    logic                w_high;
    logic [VAL_W:0]      w_vdiff;
    logic [VAL_W:0]      w_range;
    logic                w_s_acc;
    logic                w_load;
    logic [OUT_W-1:0]    w_new_min;
    logic [OUT_W-1:0]    w_new_max;

    rfnm_cfg #(
        .MAX_SIDE (MAX_SIDE)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    rfnm_iter u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_req),
        .o_busy   (w_it_busy),
        .o_done   (w_it_done),
        .o_result (w_it_result)
    );

    assign w_xx  = (2*POS_W+2)'(r_x) * (2*POS_W+2)'(r_x);
    assign w_yy  = (2*POS_W+2)'(r_y) * (2*POS_W+2)'(r_y);
    assign w_rh  = RH_W'(w_cfg.radius) * RH_W'(w_cfg.half);
    assign w_rh2 = (2*RH_W)'(r_rh) * (2*RH_W)'(r_rh);
    assign w_prod = (2*OUT_W)'(r_t) * (2*OUT_W)'(r_factor);

    assign w_num      = {r_d2, 32'd0};
    assign w_num_ext  = BIG_W'(w_num);
    assign w_big_zero = (r_big == '0);
    assign w_outside  = (w_num_ext > r_big);

    assign w_degen = ($signed(w_cfg.old_max) <= $signed(w_cfg.old_min));
    assign w_low   = (r_val <= $signed(w_cfg.old_min));
    assign w_high  = (r_val >= $signed(w_cfg.old_max));
    assign w_vdiff = {r_val[VAL_W-1], r_val} - {w_cfg.old_min[VAL_W-1], w_cfg.old_min};
    assign w_range = {w_cfg.old_max[VAL_W-1], w_cfg.old_max}
                   - {w_cfg.old_min[VAL_W-1], w_cfg.old_min};

    // requests to the shared unit
    always_comb begin
        w_req = '0;
        unique case (r_state)
            ST_CHECK: begin
                if (!w_big_zero && !w_outside) begin
                    w_req.start = 1'b1;
                    if (w_num_ext == r_big) begin
                        w_req.mode  = MODE_SQRT;
                        w_req.steps = STEPS_SQRT;
                        w_req.num   = IT_W'(64'h1_0000_0000);
                    end else begin
                        w_req.mode  = MODE_DIV;
                        w_req.steps = STEPS_FALL;
                        w_req.num   = IT_W'(w_num);
                        w_req.den   = IT_W'(r_big);
                    end
                end
            end
            ST_DIV: begin
                if (w_it_done) begin
                    w_req.start = 1'b1;
                    w_req.mode  = MODE_SQRT;
                    w_req.steps = STEPS_SQRT;
                    w_req.num   = IT_W'(w_it_result);
                end
            end
            ST_SQRT: begin
                if (w_it_done && !(w_degen || w_low || w_high)) begin
                    w_req.start = 1'b1;
                    w_req.mode  = MODE_DIV;
                    w_req.steps = STEPS_NORM;
                    w_req.num   = IT_W'(w_vdiff);
                    w_req.den   = IT_W'(w_range);
                end
            end
            default: ;
        endcase
    end

    assign w_s_acc   = i_s_tvalid && o_s_tready;
    assign w_load    = (r_state == ST_DONE) && (!r_out_valid || i_m_tready);
    assign w_new_min = (r_masked < r_least) ? r_masked : r_least;
    assign w_new_max = (r_masked > r_greatest) ? r_masked : r_greatest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_least     <= ONE_Q16;
            r_greatest  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_least     <= r_last ? ONE_Q16 : w_new_min;
                r_greatest  <= r_last ? '0 : w_new_max;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE:  if (w_s_acc) r_state <= ST_MUL1;
                ST_MUL1:  r_state <= ST_MUL2;
                ST_MUL2:  r_state <= ST_CHECK;
                ST_CHECK: begin
                    if (w_big_zero || w_outside) begin
                        r_state <= ST_DONE;
                    end else if (w_num_ext == r_big) begin
                        r_state <= ST_SQRT;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV:   if (w_it_done) r_state <= ST_SQRT;
                ST_SQRT: begin
                    if (w_it_done) begin
                        r_state <= (w_degen || w_low || w_high) ? ST_PROD : ST_NORM;
                    end
                end
                ST_NORM:  if (w_it_done) r_state <= ST_PROD;
                ST_PROD:  r_state <= ST_DONE;
                ST_DONE:  if (w_load) r_state <= ST_IDLE;
                default:  r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_val  <= i_s_tdata[VAL_W-1:0];
            r_x    <= $signed({1'b0, w_cfg.half}) - $signed({1'b0, i_s_tdata[41:32]});
            r_y    <= $signed({1'b0, w_cfg.half}) - $signed({1'b0, i_s_tdata[51:42]});
            r_last <= i_s_tlast;
        end
        if (r_state == ST_MUL1) begin
            r_xx <= w_xx[SQ_W-1:0];
            r_yy <= w_yy[SQ_W-1:0];
            r_rh <= w_rh;
        end
        if (r_state == ST_MUL2) begin
            r_d2  <= D2_W'(r_xx) + D2_W'(r_yy);
            r_big <= {w_rh2, 1'b0};
        end
        if (r_state == ST_CHECK && (w_big_zero || w_outside)) begin
            r_masked <= '0;
        end
        if (r_state == ST_SQRT && w_it_done) begin
            r_factor <= ONE_Q16 - w_it_result[OUT_W-1:0];
            r_t      <= (w_degen || w_low) ? '0 : ONE_Q16;
        end
        if (r_state == ST_NORM && w_it_done) begin
            r_t <= w_it_result[OUT_W-1:0];
        end
        if (r_state == ST_PROD) begin
            r_masked <= w_prod[OUT_W+15:16];
        end
        if (w_load) begin
            r_out_masked <= r_masked;
            r_out_min    <= w_new_min;
            r_out_max    <= w_new_max;
            r_out_last   <= r_last;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(TDATA_W-3*OUT_W){1'b0}}, r_out_max, r_out_min, r_out_masked};
    assign o_m_tlast  = r_out_last;

    a_start_idle_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_it_busy)
        else $error("shared unit started while busy");

    a_accept_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> (r_state == ST_MUL1))
        else $error("accepted word did not enter the multiply stage");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_it_done |-> (r_state == ST_DIV || r_state == ST_SQRT || r_state == ST_NORM))
        else $error("shared unit finished outside a wait state");

    a_trackers_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out_min <= r_out_masked && r_out_masked <= r_out_max
                        && r_out_max <= ONE_Q16))
        else $error("running min/max do not bracket the masked value");

endmodule
